@@ design/slri_pkg.sv @@
// Shared constants, codes and control types of the sorted list block.
package slri_pkg;

  localparam int DEPTH_DEFAULT       = 64;
  localparam int VALUE_WIDTH_DEFAULT = 16;

  localparam int STATUS_WIDTH = 2;

  // Result status codes.
  localparam logic [STATUS_WIDTH-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_RANGE = 2'd2;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic eval;    // latch the per-cell decision for this request
    logic enable;  // the request is carried out (not dropped or ignored)
    logic apply;   // move the entries
    logic remove;  // the request is a remove
  } cell_ctrl_t;

endpackage

@@ design/slri_cell.sv @@
// One storage cell of the sorted list row: an entry, its compare and its shift control.
module slri_cell #(
  parameter int VALUE_WIDTH = slri_pkg::VALUE_WIDTH_DEFAULT,
  parameter int INDEX_WIDTH = 6,
  parameter int COUNT_WIDTH = 7,
  parameter int CELL_POS    = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slri_pkg::cell_ctrl_t   ctrl_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [INDEX_WIDTH-1:0] index_i,
  input  logic [COUNT_WIDTH-1:0] count_i,
  input  logic [VALUE_WIDTH-1:0] lower_entry_i,
  input  logic [VALUE_WIDTH-1:0] upper_entry_i,
  input  logic                   lower_ge_i,
  output logic                   ge_o,
  output logic [VALUE_WIDTH-1:0] entry_o,
  output logic                   hit_o
);

  localparam logic [INDEX_WIDTH-1:0] PosIdx = INDEX_WIDTH'(CELL_POS);
  localparam logic [COUNT_WIDTH-1:0] PosCnt = COUNT_WIDTH'(CELL_POS);

  logic [VALUE_WIDTH-1:0] entry_q, entry_d;
  logic                   hit_q, hit_d;
  logic                   shift_q, shift_d;
  logic                   valid;

  assign valid = PosCnt < count_i;
  // An empty slot counts as greater, so the flags rise once along the row.
  assign ge_o  = !valid || (entry_q >= value_i);

  always_comb begin
    if (ctrl_i.remove) begin
      hit_d   = ctrl_i.enable && (index_i == PosIdx);
      shift_d = ctrl_i.enable && (index_i <= PosIdx);
    end else begin
      hit_d   = ctrl_i.enable && ge_o && !lower_ge_i;
      shift_d = ctrl_i.enable && lower_ge_i;
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (shift_q) begin
      entry_d = ctrl_i.remove ? upper_entry_i : lower_entry_i;
    end else if (hit_q && !ctrl_i.remove) begin
      entry_d = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      shift_q <= 1'b0;
    end else if (ctrl_i.eval) begin
      hit_q   <= hit_d;
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

@@ design/slri_enc.sv @@
// One-hot select across the cell row: position and entry of the marked cell.
module slri_enc #(
  parameter int DEPTH       = slri_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = slri_pkg::VALUE_WIDTH_DEFAULT,
  parameter int INDEX_WIDTH = 6
) (
  input  logic [DEPTH-1:0]                  hit_i,
  input  logic [DEPTH-1:0][VALUE_WIDTH-1:0] entries_i,
  output logic [INDEX_WIDTH-1:0]            position_o,
  output logic [VALUE_WIDTH-1:0]            value_o
);

  always_comb begin
    position_o = '0;
    value_o    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      position_o = position_o | ({INDEX_WIDTH{hit_i[i]}} & INDEX_WIDTH'(i));
      value_o    = value_o | ({VALUE_WIDTH{hit_i[i]}} & entries_i[i]);
    end
  end

endmodule

@@ design/sorted_list_insert_remove.sv @@
// Top level of the sorted list block: request sequencing, cell row and result register.
//
// The block keeps an ascending list of up to DEPTH unsigned values in a row of cells, one
// entry per cell. An insert request places its value in front of the first stored entry
// that is greater than or equal to it, so equal values keep newest-first order, and later
// entries move up one cell. A remove request deletes the entry at the given index and later
// entries move down one cell. An insert into a full list is dropped with status full, and a
// remove at or beyond the stored count is ignored with status range; both leave the list as
// it was and report position and entry value as zero. Every request produces exactly one
// result. At the accepting edge of a request every cell compares its entry with the new
// value (or its own place with the index) and latches whether it moves or takes the new
// value; once the output register is free, the whole row shifts at once and the result is
// loaded into the output register. The input is stalled until that load, which waits only
// while a previous result still sits in the output register, so a new request is taken
// only once the last one is through. The list contents are undefined after reset; only the
// entry count is cleared, and no clearing pass is needed.
module sorted_list_insert_remove #(
  parameter int DEPTH       = slri_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = slri_pkg::VALUE_WIDTH_DEFAULT,
  localparam int INDEX_WIDTH = $clog2(DEPTH),
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              in_command_i,
  input  logic [VALUE_WIDTH-1:0]            in_value_i,
  input  logic [INDEX_WIDTH-1:0]            in_index_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [slri_pkg::STATUS_WIDTH-1:0] out_status_o,
  output logic [INDEX_WIDTH-1:0]            out_position_o,
  output logic [VALUE_WIDTH-1:0]            out_entry_value_o,
  output logic [COUNT_WIDTH-1:0]            out_entry_count_o
);

  // Sequencer states.
  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  localparam logic [COUNT_WIDTH-1:0] FullCount = COUNT_WIDTH'(DEPTH);

  logic state_q, state_d;

  // Request held for the apply cycle.
  logic                              cmd_q;
  logic [VALUE_WIDTH-1:0]            value_q;
  logic [INDEX_WIDTH-1:0]            index_q;
  logic                              do_q;
  logic [slri_pkg::STATUS_WIDTH-1:0] status_q;

  logic [COUNT_WIDTH-1:0] count_q, count_d;

  // Result register.
  logic                              out_valid_q, out_valid_d;
  logic [slri_pkg::STATUS_WIDTH-1:0] out_status_q;
  logic [INDEX_WIDTH-1:0]            out_position_q;
  logic [VALUE_WIDTH-1:0]            out_entry_value_q;
  logic [COUNT_WIDTH-1:0]            out_entry_count_q;

  logic                              in_accept;
  logic                              result_load;
  logic                              is_full;
  logic                              out_of_range;
  logic                              do_op;
  logic [slri_pkg::STATUS_WIDTH-1:0] status_d;

  slri_pkg::cell_ctrl_t              ctrl;
  logic [VALUE_WIDTH-1:0]            cell_value;

  logic [DEPTH-1:0]                  ge;
  logic [DEPTH-1:0]                  hit;
  logic [DEPTH-1:0][VALUE_WIDTH-1:0] entries;

  logic [INDEX_WIDTH-1:0]            enc_position;
  logic [VALUE_WIDTH-1:0]            enc_value;

  // The input waits while an accepted request has not yet been applied.
  assign in_stall_o  = (state_q == S_APPLY);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign result_load = (state_q == S_APPLY) && (!out_valid_q || !out_stall_i);

  // Decide at acceptance whether the request is carried out.
  assign is_full      = (count_q == FullCount);
  assign out_of_range = (COUNT_WIDTH'(in_index_i) >= count_q);

  always_comb begin
    if (in_command_i == slri_pkg::CMD_REMOVE) begin
      do_op    = !out_of_range;
      status_d = out_of_range ? slri_pkg::ST_RANGE : slri_pkg::ST_DONE;
    end else begin
      do_op    = !is_full;
      status_d = is_full ? slri_pkg::ST_FULL : slri_pkg::ST_DONE;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_accept) state_d = S_APPLY;
      S_APPLY: if (result_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // The cells see the live request while accepting and the held one while shifting.
  always_comb begin
    ctrl.eval   = in_accept;
    ctrl.enable = do_op;
    ctrl.apply  = result_load && do_q;
    if (state_q == S_APPLY) begin
      ctrl.remove = (cmd_q == slri_pkg::CMD_REMOVE);
      cell_value  = value_q;
    end else begin
      ctrl.remove = (in_command_i == slri_pkg::CMD_REMOVE);
      cell_value  = in_value_i;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] lower_entry;
    logic [VALUE_WIDTH-1:0] upper_entry;
    logic                   lower_ge;

    if (i == 0) begin : g_first
      assign lower_entry = '0;
      assign lower_ge    = 1'b0;
    end else begin : g_inner
      assign lower_entry = entries[i-1];
      assign lower_ge    = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_entry = entries[i];
    end else begin : g_below
      assign upper_entry = entries[i+1];
    end

    slri_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .INDEX_WIDTH (INDEX_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH),
      .CELL_POS    (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .value_i       (cell_value),
      .index_i       (in_index_i),
      .count_i       (count_q),
      .lower_entry_i (lower_entry),
      .upper_entry_i (upper_entry),
      .lower_ge_i    (lower_ge),
      .ge_o          (ge[i]),
      .entry_o       (entries[i]),
      .hit_o         (hit[i])
    );
  end

  // The marked cell gives the insert position or the removed entry.
  slri_enc #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_enc (
    .hit_i      (hit),
    .entries_i  (entries),
    .position_o (enc_position),
    .value_o    (enc_value)
  );

  always_comb begin
    count_d = count_q;
    if (result_load && do_q) begin
      if (cmd_q == slri_pkg::CMD_REMOVE) begin
        count_d = count_q - COUNT_WIDTH'(1);
      end else begin
        count_d = count_q + COUNT_WIDTH'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (result_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      do_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        do_q <= do_op;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= in_command_i;
      value_q  <= in_value_i;
      index_q  <= in_index_i;
      status_q <= status_d;
    end
    if (result_load) begin
      out_status_q      <= status_q;
      out_entry_count_q <= count_d;
      if (!do_q) begin
        out_position_q    <= '0;
        out_entry_value_q <= '0;
      end else if (cmd_q == slri_pkg::CMD_REMOVE) begin
        out_position_q    <= index_q;
        out_entry_value_q <= enc_value;
      end else begin
        out_position_q    <= enc_position;
        out_entry_value_q <= value_q;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_position_o    = out_position_q;
  assign out_entry_value_o = out_entry_value_q;
  assign out_entry_count_o = out_entry_count_q;

  // The list never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count exceeds depth");

  // At most one cell is marked while a request is being applied.
  a_hit_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) |-> $onehot0(hit))
    else $error("more than one cell marked");

  // A carried-out insert marks exactly one cell.
  a_insert_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_APPLY) && do_q && (cmd_q == slri_pkg::CMD_INSERT)) |-> $onehot(hit))
    else $error("insert found no position");

  // A dropped or ignored request leaves the count unchanged.
  a_reject_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_load && !do_q) |=> $stable(count_q))
    else $error("rejected request changed the count");

  // The reported count always matches the count held after the request.
  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_load |=> (out_entry_count_q == count_q))
    else $error("result count disagrees with stored count");

endmodule

@@ sim/sorted_list_insert_remove_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the sorted list block: directed table, random requests, checker.
module sorted_list_insert_remove_test;

  // The block is built at its default size. With 64 entries the index and position are
  // six bits wide and the entry count seven bits.
  localparam int LIST_DEPTH  = 64;
  localparam int VAL_W       = 16;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;

  // Run shaping. The random part is cut into segments, and each segment pushes the list
  // toward full, toward empty or keeps it level, so that both ends are visited often.
  localparam int SEGMENTS    = 10;
  localparam int SEGMENT_LEN = 42;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 8;

  // One result as the block reports it.
  typedef struct packed {
    logic [slri_pkg::STATUS_WIDTH-1:0] status;
    logic [IDX_W-1:0]                  position;
    logic [VAL_W-1:0]                  entry_value;
    logic [CNT_W-1:0]                  entry_count;
  } list_result_t;

  localparam list_result_t NO_RESULT = '0;

  // One row of the directed table. A row may be sent several times in a row, and may
  // take a fresh random value each time. Where the result is obvious it is typed in;
  // every other row is checked against the predictor.
  typedef struct {
    logic         cmd;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    int           copies;
    bit           random_value;
    bit           typed;
    list_result_t expected;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 20;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Removes from an empty list are ignored, at the lowest and the highest index.
    '{slri_pkg::CMD_REMOVE, 16'h0000, 6'd0,  1, 1'b0, 1'b1,
      '{slri_pkg::ST_RANGE, 6'd0, 16'h0000, 7'd0}},
    '{slri_pkg::CMD_REMOVE, 16'hFFFF, 6'd63, 1, 1'b0, 1'b1,
      '{slri_pkg::ST_RANGE, 6'd0, 16'h0000, 7'd0}},
    // The smallest and the largest value go in at the two ends.
    '{slri_pkg::CMD_INSERT, 16'h0000, 6'd0,  1, 1'b0, 1'b1,
      '{slri_pkg::ST_DONE,  6'd0, 16'h0000, 7'd1}},
    '{slri_pkg::CMD_INSERT, 16'hFFFF, 6'd63, 1, 1'b0, 1'b1,
      '{slri_pkg::ST_DONE,  6'd1, 16'hFFFF, 7'd2}},
    // A value in the middle, then an equal one, which lands in front of its twin.
    '{slri_pkg::CMD_INSERT, 16'd100,  6'd0,  1, 1'b0, 1'b0, NO_RESULT},
    '{slri_pkg::CMD_INSERT, 16'd100,  6'd0,  1, 1'b0, 1'b0, NO_RESULT},
    '{slri_pkg::CMD_INSERT, 16'h0000, 6'd0,  1, 1'b0, 1'b0, NO_RESULT},
    // A remove just past the last entry is ignored.
    '{slri_pkg::CMD_REMOVE, 16'h0000, 6'd5,  1, 1'b0, 1'b1,
      '{slri_pkg::ST_RANGE, 6'd0, 16'h0000, 7'd5}},
    // Remove the last entry, then the first.
    '{slri_pkg::CMD_REMOVE, 16'h0000, 6'd4,  1, 1'b0, 1'b0, NO_RESULT},
    '{slri_pkg::CMD_REMOVE, 16'h0000, 6'd0,  1, 1'b0, 1'b0, NO_RESULT},
    // Values around the sign boundary and alternating bit patterns.
    '{slri_pkg::CMD_INSERT, 16'h8000, 6'd0,  1, 1'b0, 1'b0, NO_RESULT},
    '{slri_pkg::CMD_INSERT, 16'h7FFF, 6'd0,  1, 1'b0, 1'b0, NO_RESULT},
    '{slri_pkg::CMD_INSERT, 16'h5555, 6'd0,  1, 1'b0, 1'b0, NO_RESULT},
    '{slri_pkg::CMD_INSERT, 16'hAAAA, 6'd0,  1, 1'b0, 1'b0, NO_RESULT},
    // Fill the list with random values; the last few inserts find it full.
    '{slri_pkg::CMD_INSERT, 16'h0000, 6'd0, 60, 1'b1, 1'b0, NO_RESULT},
    '{slri_pkg::CMD_INSERT, 16'h0001, 6'd0,  1, 1'b0, 1'b1,
      '{slri_pkg::ST_FULL,  6'd0, 16'h0000, 7'd64}},
    // Remove the top entry of a full list and fill it again with the largest value.
    '{slri_pkg::CMD_REMOVE, 16'h0000, 6'd63, 1, 1'b0, 1'b0, NO_RESULT},
    '{slri_pkg::CMD_INSERT, 16'hFFFF, 6'd0,  1, 1'b0, 1'b0, NO_RESULT},
    '{slri_pkg::CMD_REMOVE, 16'h0000, 6'd0,  1, 1'b0, 1'b0, NO_RESULT},
    // With 63 entries, index 63 is one past the end.
    '{slri_pkg::CMD_REMOVE, 16'h0000, 6'd63, 1, 1'b0, 1'b1,
      '{slri_pkg::ST_RANGE, 6'd0, 16'h0000, 7'd63}}
  };

  // Clock, reset and the two channels. Every input of the block is known from time zero.
  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_stall;
  logic             in_command      = slri_pkg::CMD_INSERT;
  logic [VAL_W-1:0] in_value        = '0;
  logic [IDX_W-1:0] in_index        = '0;
  logic             out_valid;
  logic             out_stall       = 1'b0;
  logic [slri_pkg::STATUS_WIDTH-1:0] out_status;
  logic [IDX_W-1:0] out_position;
  logic [VAL_W-1:0] out_entry_value;
  logic [CNT_W-1:0] out_entry_count;

  // Predicted contents of the list and the results still owed by the block.
  logic [VAL_W-1:0] list_entries [LIST_DEPTH];
  int               list_count = 0;
  list_result_t     expected_results [$];
  int               error_count = 0;

  // Flags shared between the request side and the result side. The request side asks for
  // a long hold-off of the results, and chooses per segment whether each side runs
  // without gaps.
  bit hold_req = 1'b0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  always #10 clk = ~clk;

  sorted_list_insert_remove #(
    .DEPTH       (LIST_DEPTH),
    .VALUE_WIDTH (VAL_W)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .in_command_i      (in_command),
    .in_value_i        (in_value),
    .in_index_i        (in_index),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_status_o      (out_status),
    .out_position_o    (out_position),
    .out_entry_value_o (out_entry_value),
    .out_entry_count_o (out_entry_count)
  );

  // Carries out one request on the predicted list and returns the result it must cause.
  // An insert goes in front of the first entry that is not smaller than its value; a
  // remove closes the gap it leaves. A full list drops inserts, and an index at or past
  // the count is ignored; both report position and value as zero.
  function automatic list_result_t apply_list_request(logic cmd, logic [VAL_W-1:0] val,
                                                      logic [IDX_W-1:0] idx);
    list_result_t res;
    int           pos;
    logic [VAL_W-1:0] taken;
    res = '0;
    if (cmd == slri_pkg::CMD_INSERT) begin
      if (list_count >= LIST_DEPTH) begin
        res.status = slri_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < list_count && list_entries[pos] < val) pos++;
        for (int i = list_count; i > pos; i--) list_entries[i] = list_entries[i - 1];
        list_entries[pos] = val;
        list_count++;
        res.status      = slri_pkg::ST_DONE;
        res.position    = IDX_W'(pos);
        res.entry_value = val;
      end
    end else if (int'(idx) >= list_count) begin
      res.status = slri_pkg::ST_RANGE;
    end else begin
      taken = list_entries[idx];
      for (int i = int'(idx); i + 1 < list_count; i++) list_entries[i] = list_entries[i + 1];
      list_count--;
      res.status      = slri_pkg::ST_DONE;
      res.position    = idx;
      res.entry_value = taken;
    end
    res.entry_count = CNT_W'(list_count);
    return res;
  endfunction

  // Gap lengths: mostly none, often short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Values favor the two extremes and a narrow band, so equal entries are common.
  function automatic logic [VAL_W-1:0] pick_value();
    unique case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return VAL_W'($urandom_range(0, 7));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Most removes hit a stored entry; the rest take any index and may fall past the end.
  function automatic logic [IDX_W-1:0] pick_index();
    if (list_count > 0 && $urandom_range(0, 4) != 0)
      return IDX_W'($urandom_range(0, list_count - 1));
    return IDX_W'($urandom_range(0, LIST_DEPTH - 1));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_result(input list_result_t want);
    if (out_status !== want.status)
      report_mismatch("status", int'(out_status), int'(want.status));
    if (out_position !== want.position)
      report_mismatch("position", int'(out_position), int'(want.position));
    if (out_entry_value !== want.entry_value)
      report_mismatch("entry value", int'(out_entry_value), int'(want.entry_value));
    if (out_entry_count !== want.entry_count)
      report_mismatch("entry count", int'(out_entry_count), int'(want.entry_count));
  endtask

  // Offers one request from the falling edge on and holds it until a rising edge finds
  // the input not stalled. Only then is the request carried out on the predicted list.
  task automatic send_request(input logic cmd, input logic [VAL_W-1:0] val,
                              input logic [IDX_W-1:0] idx, input bit typed,
                              input list_result_t typed_result);
    list_result_t predicted;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    in_index   <= idx;
    do @(posedge clk); while (in_stall);
    predicted = apply_list_request(cmd, val, idx);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  // Drops valid for the given number of cycles. Valid is lowered only here, so it never
  // falls and rises again within one time step.
  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Stops offering requests until every owed result has come, or the limit runs out.
  task automatic wait_results_drained();
    int waited;
    idle_sender(1);
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Result side. The stall is chosen at each falling edge. A long hold-off, when asked
  // for, is counted down here; the request side keeps offering meanwhile, so the block's
  // output register fills and its input stalls.
  initial begin : result_stall
    int hold_cnt;
    int stall_cnt;
    hold_cnt  = 0;
    stall_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end else if (!rx_burst && $urandom_range(0, 2) == 0) begin
        stall_cnt = gap_len();
      end
      out_stall <= (hold_cnt > 0) || (stall_cnt > 0);
    end
  end

  // Every accepted result is compared with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request owed", int'(out_status), 0);
      end else begin
        check_result(expected_results.pop_front());
      end
    end
  end

  initial begin : stimulus
    int ins_pct;
    logic [VAL_W-1:0] val;

    // Reset is asserted from time zero and released at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      for (int k = 0; k < directed_rows[r].copies; k++) begin
        val = directed_rows[r].random_value ? pick_value() : directed_rows[r].value;
        send_request(directed_rows[r].cmd, val, directed_rows[r].index,
                     directed_rows[r].typed, directed_rows[r].expected);
        idle_sender(gap_len());
      end
    end

    // The request side pauses here until the block has answered everything.
    wait_results_drained();

    // Random part. Each segment leans toward inserts or removes by its own share.
    for (int s = 0; s < SEGMENTS; s++) begin
      unique case (s % 4)
        0:       ins_pct = 20;
        1:       ins_pct = 90;
        2:       ins_pct = 5;
        default: ins_pct = $urandom_range(10, 90);
      endcase
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (s == 0) begin
        // The first segment opens with a long hold-off of the results while requests
        // keep coming back to back.
        tx_burst = 1'b1;
        hold_req = 1'b1;
      end
      if (s == SEGMENTS / 2) wait_results_drained();
      for (int n = 0; n < SEGMENT_LEN; n++) begin
        if ($urandom_range(0, 99) < ins_pct)
          send_request(slri_pkg::CMD_INSERT, pick_value(), IDX_W'($urandom), 1'b0,
                       NO_RESULT);
        else
          send_request(slri_pkg::CMD_REMOVE, VAL_W'($urandom), pick_index(), 1'b0,
                       NO_RESULT);
        if (!tx_burst) idle_sender(gap_len());
      end
    end

    // Let the last results come out and give any stray result a last chance to appear.
    rx_burst = 1'b0;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results that never came", expected_results.size(), 0);

    if (error_count == 0) begin
      $display("** sorted_list_insert_remove: PASSED **");
    end else begin
      $display("** sorted_list_insert_remove: FAILED **");
    end
    $finish;
  end

  // Timeout: far beyond the slowest correct run of about 500 requests.
  initial begin : watchdog
    #10_000_000;
    $display("** sorted_list_insert_remove: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
design/slri_pkg.sv
design/slri_cell.sv
design/slri_enc.sv
design/sorted_list_insert_remove.sv
sim/sorted_list_insert_remove_test.sv
